### rtl/sspc_pkg.sv
// shared types and constants for the servo status packet checker
`timescale 1ns / 1ps

package sspc_pkg;

    // header byte value and packet framing constants
    localparam logic [7:0] HDR_BYTE  = 8'hFF;
    localparam logic [8:0] MIN_BYTES = 9'd6;
    localparam logic [8:0] LEN_EXTRA = 9'd4;
    localparam logic [8:0] SUM_FROM  = 9'd2;
    localparam logic [8:0] IDX_MAX   = 9'd511;

    // byte positions of the captured fields
    localparam logic [8:0] POS_HDR0  = 9'd0;
    localparam logic [8:0] POS_HDR1  = 9'd1;
    localparam logic [8:0] POS_ID    = 9'd2;
    localparam logic [8:0] POS_LEN   = 9'd3;
    localparam logic [8:0] POS_ERR   = 9'd4;
    localparam logic [8:0] POS_PLOW  = 9'd5;
    localparam logic [8:0] POS_PHIGH = 9'd6;

    // verdict codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_HEADER   = 3'd2;
    localparam logic [2:0] ST_CHECKSUM = 3'd3;
    localparam logic [2:0] ST_LENGTH   = 3'd4;
    localparam logic [2:0] ST_SERVO    = 3'd5;

    // one result word
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] servo_id;
        logic [7:0] error_flags;
        logic [7:0] param_low;
        logic [7:0] param_high;
        logic [8:0] byte_total;
    } t_result;

    // handoff from the packet tracker to the output buffer
    typedef struct packed {
        logic    push;
        t_result word;
    } t_push;

endpackage

### rtl/sspc_frame.sv
// input register, packet state and verdict logic for the packet checker
`timescale 1ns / 1ps

module sspc_frame (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_last_byte,
    input  logic            i_space,
    output logic            o_stall,
    output sspc_pkg::t_push o_push
);
    import sspc_pkg::*;

    logic       r_in_v;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic [8:0] r_idx;
    logic [7:0] r_sum;
    logic       r_hdr_good;
    logic [7:0] r_id;
    logic [7:0] r_len;
    logic [7:0] r_err;
    logic [7:0] r_plow;
    logic [7:0] r_phigh;

    logic [8:0] n_idx;
    logic [7:0] n_sum;
    logic       n_hdr_good;
    logic [7:0] n_id;
    logic [7:0] n_len;
    logic [7:0] n_err;
    logic [7:0] n_plow;
    logic [7:0] n_phigh;

    logic       fire;
    logic       load;
    logic [8:0] count;
    logic [2:0] status;

    // a last word waits for room in the output buffer, others go at once
    assign fire    = r_in_v && (!r_in_last || i_space);
    assign o_stall = r_in_v && !fire;
    assign load    = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (load) begin
            r_in_v <= 1'b1;
        end else if (fire) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in_byte <= i_rx_byte;
            r_in_last <= i_last_byte;
        end
    end

    // captures and header check including the current word
    always_comb begin
        n_hdr_good = r_hdr_good;
        if ((r_idx == POS_HDR0 || r_idx == POS_HDR1) && r_in_byte != HDR_BYTE) begin
            n_hdr_good = 1'b0;
        end
        n_id    = (r_idx == POS_ID)    ? r_in_byte : r_id;
        n_len   = (r_idx == POS_LEN)   ? r_in_byte : r_len;
        n_err   = (r_idx == POS_ERR)   ? r_in_byte : r_err;
        n_plow  = (r_idx == POS_PLOW)  ? r_in_byte : r_plow;
        n_phigh = (r_idx == POS_PHIGH) ? r_in_byte : r_phigh;
    end

    // saturating byte count and running sum
    assign count = (r_idx < IDX_MAX) ? r_idx + 9'd1 : IDX_MAX;
    assign n_idx = count;
    assign n_sum = (r_idx >= SUM_FROM) ? r_sum + r_in_byte : r_sum;

    // verdict, checks in priority order
    always_comb begin
        priority if (count < MIN_BYTES) begin
            status = ST_SHORT;
        end else if (!n_hdr_good) begin
            status = ST_HEADER;
        end else if (~r_sum != r_in_byte) begin
            status = ST_CHECKSUM;
        end else if ({1'b0, n_len} + LEN_EXTRA != count) begin
            status = ST_LENGTH;
        end else if (n_err != 8'd0) begin
            status = ST_SERVO;
        end else begin
            status = ST_OK;
        end
    end

    // packet state, cleared after each verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_sum      <= '0;
            r_hdr_good <= 1'b1;
            r_id       <= '0;
            r_len      <= '0;
            r_err      <= '0;
            r_plow     <= '0;
            r_phigh    <= '0;
        end else if (fire) begin
            if (r_in_last) begin
                r_idx      <= '0;
                r_sum      <= '0;
                r_hdr_good <= 1'b1;
                r_id       <= '0;
                r_len      <= '0;
                r_err      <= '0;
                r_plow     <= '0;
                r_phigh    <= '0;
            end else begin
                r_idx      <= n_idx;
                r_sum      <= n_sum;
                r_hdr_good <= n_hdr_good;
                r_id       <= n_id;
                r_len      <= n_len;
                r_err      <= n_err;
                r_plow     <= n_plow;
                r_phigh    <= n_phigh;
            end
        end
    end

    // result word toward the output buffer
    always_comb begin
        o_push.push             = fire && r_in_last;
        o_push.word.status      = status;
        o_push.word.servo_id    = n_id;
        o_push.word.error_flags = n_err;
        o_push.word.param_low   = n_plow;
        o_push.word.param_high  = n_phigh;
        o_push.word.byte_total  = count;
    end

    // checks
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_last |=> r_idx == '0 && r_sum == '0 && r_hdr_good)
        else $error("packet state not cleared after verdict");

    a_idx_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !r_in_last && r_idx < IDX_MAX |=> r_idx == $past(r_idx) + 9'd1)
        else $error("byte index did not advance");

    a_idx_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_v && !fire |=> r_idx == $past(r_idx) && r_in_v)
        else $error("stalled word changed packet state");

endmodule

### rtl/sspc_out_buf.sv
// two-entry result buffer that parts the result side from the byte side
`timescale 1ns / 1ps

module sspc_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sspc_pkg::t_push   i_push,
    input  logic              i_stall,
    output logic              o_space,
    output logic              o_valid,
    output sspc_pkg::t_result o_word
);
    import sspc_pkg::*;

    t_result    r_q0;
    t_result    r_q1;
    logic [1:0] r_count;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_space = (r_count != 2'd2);
    assign pop     = o_valid && !i_stall;
    assign o_word  = r_q0;

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (i_push.push && !pop) begin
            r_count <= r_count + 2'd1;
        end else if (pop && !i_push.push) begin
            r_count <= r_count - 2'd1;
        end
    end

    // entry data, head in slot zero
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_q0 <= (i_push.push && r_count == 2'd1) ? i_push.word : r_q1;
            if (i_push.push && r_count == 2'd2) begin
                r_q1 <= i_push.word;
            end
        end else if (i_push.push) begin
            if (r_count == 2'd0) begin
                r_q0 <= i_push.word;
            end else begin
                r_q1 <= i_push.word;
            end
        end
    end

    // checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.push && r_count == 2'd2))
        else $error("push into full result buffer");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result buffer count out of range");

    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && o_word == $past(o_word))
        else $error("stalled result word changed");

endmodule

### rtl/servo_status_packet_checker_core.sv
// top level of the servo status packet checker
// result path: a last byte is held in the input register, then its word enters the result buffer
// throughput: one byte per cycle, sustained; a last byte waits only while the
// two-entry result buffer is full
// reset: synchronous active-low reset empties the input register and the result
// buffer and returns the packet state to byte index zero with a good header
`timescale 1ns / 1ps

module servo_status_packet_checker_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_status,
    output logic [7:0] o_servo_id,
    output logic [7:0] o_error_flags,
    output logic [7:0] o_param_low,
    output logic [7:0] o_param_high,
    output logic [8:0] o_byte_total
);
    import sspc_pkg::*;

    t_push   push;
    t_result word;
    logic    space;

    // packet tracking and verdict
    sspc_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_rx_byte   (i_rx_byte),
        .i_last_byte (i_last_byte),
        .i_space     (space),
        .o_stall     (o_stall),
        .o_push      (push)
    );

    // result buffer
    sspc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_stall (i_stall),
        .o_space (space),
        .o_valid (o_valid),
        .o_word  (word)
    );

    // result fields
    assign o_status      = word.status;
    assign o_servo_id    = word.servo_id;
    assign o_error_flags = word.error_flags;
    assign o_param_low   = word.param_low;
    assign o_param_high  = word.param_high;
    assign o_byte_total  = word.byte_total;

endmodule
